### src/scfla_pkg.sv
package scfla_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned SizeW   = 12;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatW   = 2;
  localparam int unsigned RefillW = 7;
  localparam int unsigned LimitW  = 17;

  localparam logic [CmdW-1:0] CmdAlloc   = 2'd0;
  localparam logic [CmdW-1:0] CmdFree    = 2'd1;
  localparam logic [CmdW-1:0] CmdRealloc = 2'd2;

  localparam logic [StatW-1:0] StatOk    = 2'd0;
  localparam logic [StatW-1:0] StatOom   = 2'd1;
  localparam logic [StatW-1:0] StatRange = 2'd2;

  localparam logic [0:0] RegRefill = 1'b0;
  localparam logic [0:0] RegLimit  = 1'b1;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [AddrW-1:0] address;
    logic [SizeW-1:0] size;
    logic [SizeW-1:0] new_size;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] block_address;
    logic [StatW-1:0] status;
  } rsp_t;

endpackage

### src/size_class_free_list_allocator_unit.sv
// A free pushes onto its class list and an alloc pops from its list; if that list
// is empty, the alloc carves a refill from the pool (out of memory if none fits).
// A reallocate frees before it allocates. The back end takes one transaction at
// a time, the front end queues up to two, and refills are amortized over later pops.
// Reset clears class heads (by valid bits), the bump pointer and all
// control state; the link memory is undefined until written.
module size_class_free_list_allocator_unit #(
  parameter int unsigned ALIGN_BYTES     = 8,
  parameter int unsigned MAX_SMALL_BYTES = 256,
  parameter int unsigned NUM_CLASSES     = 32,
  parameter int unsigned POOL_BYTES      = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  scfla_pkg::req_t  req_i,
  output logic             empty,
  input  logic             pop,
  output scfla_pkg::rsp_t  rsp_o,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index_i,
  input  logic [16:0]      cfg_data_i
);

  localparam int unsigned LinkDepth = POOL_BYTES / ALIGN_BYTES;
  localparam int unsigned ClsW  = $clog2(NUM_CLASSES);
  localparam int unsigned GranW = $clog2(LinkDepth);
  localparam int unsigned OpW   = 2 + 1 + ClsW + 1 + ClsW + GranW;

  // Configuration registers; writes are always accepted.
  logic [scfla_pkg::RefillW-1:0] refill_q;
  logic [scfla_pkg::LimitW-1:0]  limit_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refill_q <= 7'd20;
      limit_q  <= 17'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        scfla_pkg::RegRefill: refill_q <= cfg_data_i[scfla_pkg::RefillW-1:0];
        scfla_pkg::RegLimit:  limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic           op_valid, op_ready;
  logic [OpW-1:0] op;
  logic           rsp_valid;

  // The front end classifies each transaction and queues the decoded operation.
  scfla_front #(
    .AlignBytes(ALIGN_BYTES), .MaxSmallBytes(MAX_SMALL_BYTES),
    .NumClasses(NUM_CLASSES), .LinkDepth(LinkDepth)
  ) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .req_i,
    .op_valid_o(op_valid), .op_ready_i(op_ready), .op_o(op)
  );

  // The back end updates lists, carves refills and holds the result.
  scfla_back #(
    .AlignBytes(ALIGN_BYTES), .NumClasses(NUM_CLASSES), .PoolBytes(POOL_BYTES)
  ) u_back (
    .clk_i, .rst_ni, .op_valid_i(op_valid), .op_ready_o(op_ready), .op_i(op),
    .refill_i(refill_q), .limit_i(limit_q),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(pop), .rsp_o
  );

  assign empty = !rsp_valid;

endmodule

### src/scfla_front.sv
module scfla_front #(
  parameter int unsigned AlignBytes    = 8,
  parameter int unsigned MaxSmallBytes = 256,
  parameter int unsigned NumClasses    = 32,
  parameter int unsigned LinkDepth     = 8192,
  localparam int unsigned ClsW   = $clog2(NumClasses),
  localparam int unsigned GranW  = $clog2(LinkDepth),
  localparam int unsigned OpW    = 2 + 1 + ClsW + 1 + ClsW + GranW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  scfla_pkg::req_t     req_i,
  output logic                op_valid_o,
  input  logic                op_ready_i,
  output logic [OpW-1:0]      op_o
);

  localparam int unsigned ShW = $clog2(AlignBytes);

  // op: {has_free, free_cls, has_alloc, alloc_cls, granule, status_pre}
  logic [OpW-1:0] q_mem [2];
  logic           wr_q, rd_q, wr_d, rd_d;
  logic [1:0]     cnt_q, cnt_d;

  function automatic logic [ClsW:0] classify(logic [scfla_pkg::SizeW-1:0] s);
    logic [scfla_pkg::SizeW-1:0] c;
    c = (s - 1'b1) >> ShW;
    if (s == '0 || 32'(s) > MaxSmallBytes || 32'(c) >= NumClasses) return '0;
    return {1'b1, c[ClsW-1:0]};
  endfunction

  logic [ClsW:0]   c_old, c_new;
  logic            has_free, has_alloc;
  logic [1:0]      pre;
  logic [GranW-1:0] gran;

  always_comb begin
    c_old = classify(req_i.size);
    c_new = classify(req_i.new_size);
    has_free = 1'b0;
    has_alloc = 1'b0;
    pre = scfla_pkg::StatOk;
    gran = GranW'(req_i.address >> ShW);
    unique case (req_i.command)
      scfla_pkg::CmdAlloc: begin
        has_alloc = c_old[ClsW];
        if (!c_old[ClsW]) pre = scfla_pkg::StatRange;
      end
      scfla_pkg::CmdFree: begin
        has_free = c_old[ClsW];
        if (!c_old[ClsW]) pre = scfla_pkg::StatRange;
      end
      scfla_pkg::CmdRealloc: begin
        has_free = c_old[ClsW];
        has_alloc = c_old[ClsW] && c_new[ClsW];
        if (!has_alloc) pre = scfla_pkg::StatRange;
      end
      default: ;
    endcase
  end

  logic [ClsW-1:0] a_cls;
  assign a_cls = (req_i.command == scfla_pkg::CmdRealloc) ? c_new[ClsW-1:0]
                                                           : c_old[ClsW-1:0];

  logic do_push, do_pop;
  assign full_o   = (cnt_q == 2'd2);
  assign do_push  = push_i && !full_o;
  assign op_valid_o = (cnt_q != 2'd0);
  assign do_pop   = op_valid_o && op_ready_i;
  assign op_o     = q_mem[rd_q];

  always_comb begin
    wr_d = do_push ? ~wr_q : wr_q;
    rd_d = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= {has_free, c_old[ClsW-1:0], has_alloc, a_cls, gran, pre};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("op queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !do_pop) else $error("pop from empty op queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q == rd_q) |-> (cnt_q == 2'd0 || cnt_q == 2'd2))
    else $error("op queue pointers inconsistent");

endmodule

### src/scfla_back.sv
module scfla_back #(
  parameter int unsigned AlignBytes = 8,
  parameter int unsigned NumClasses = 32,
  parameter int unsigned PoolBytes  = 65536,
  localparam int unsigned LinkDepth = PoolBytes / AlignBytes,
  localparam int unsigned ClsW   = $clog2(NumClasses),
  localparam int unsigned GranW  = $clog2(LinkDepth),
  localparam int unsigned PtrW   = $clog2(PoolBytes) + 1,
  localparam int unsigned OpW    = 2 + 1 + ClsW + 1 + ClsW + GranW
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           op_valid_i,
  output logic                           op_ready_o,
  input  logic [OpW-1:0]                 op_i,
  input  logic [scfla_pkg::RefillW-1:0]  refill_i,
  input  logic [scfla_pkg::LimitW-1:0]   limit_i,
  output logic                           rsp_valid_o,
  input  logic                           rsp_ready_i,
  output scfla_pkg::rsp_t                rsp_o
);

  localparam int unsigned ShW = $clog2(AlignBytes);
  localparam int unsigned HW  = GranW + 1;
  localparam int unsigned LW  = PtrW + 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFree  = 3'd1;
  localparam logic [2:0] StPop   = 3'd2;
  localparam logic [2:0] StLink  = 3'd3;
  localparam logic [2:0] StFit   = 3'd4;
  localparam logic [2:0] StCarve = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] st_q, st_d;

  logic [HW-1:0]   heads_q [NumClasses];
  logic [NumClasses-1:0] hvalid_q;
  logic [HW-1:0]   link_mem [LinkDepth];
  logic [HW-1:0]   link_rd_q;

  logic             free_f, alloc_f;
  logic [ClsW-1:0]  free_c, alloc_c;
  logic [GranW-1:0] gran;
  logic [1:0]       pre;
  assign {free_f, free_c, alloc_f, alloc_c, gran, pre} = op_i;

  logic [PtrW-1:0]  next_q;
  logic [PtrW-1:0]  objb_q;
  logic [PtrW-1:0]  fit_q;
  logic [PtrW-1:0]  rem_q;
  logic [PtrW-1:0]  cnt_q;
  logic [PtrW-1:0]  k_q;
  logic [PtrW-1:0]  cur_q;
  logic [GranW-1:0] pop_g_q;
  scfla_pkg::rsp_t  res_q;
  scfla_pkg::rsp_t  out_q;
  logic             outv_q;

  logic [HW-1:0] head_cur;
  assign head_cur = hvalid_q[alloc_c] ? heads_q[alloc_c] : '0;

  logic [PtrW-1:0] lim_sat, nbytes, cnt_req;
  assign lim_sat = (LW'(limit_i) > LW'(PoolBytes)) ? PtrW'(PoolBytes) : PtrW'(limit_i);
  assign nbytes  = PtrW'((PtrW'(alloc_c) + 1'b1) << ShW);
  assign cnt_req = (refill_i == '0) ? PtrW'(1) : PtrW'(refill_i);

  logic [PtrW-1:0] nxt_obj;
  assign nxt_obj = cur_q + objb_q;

  assign op_ready_o  = (st_q == StOut) && (!outv_q || rsp_ready_i);
  assign rsp_valid_o = outv_q;
  assign rsp_o       = out_q;

  logic link_we;
  logic [GranW-1:0] link_wa;
  logic [HW-1:0] link_wd;

  always_comb begin
    st_d = st_q;
    link_we = 1'b0;
    link_wa = gran;
    link_wd = '0;
    unique case (st_q)
      StIdle: if (op_valid_i) st_d = free_f ? StFree : (alloc_f ? StPop : StOut);
      StFree: begin
        link_we = 1'b1;
        link_wa = gran;
        link_wd = hvalid_q[free_c] ? heads_q[free_c] : '0;
        st_d = alloc_f ? StPop : StOut;
      end
      StPop: st_d = (head_cur != '0) ? StLink : StFit;
      StLink: st_d = StOut;
      StFit: if (rem_q < objb_q || fit_q >= cnt_req) st_d = StCarve;
      StCarve: begin
        if (k_q < cnt_q) begin
          link_we = 1'b1;
          link_wa = GranW'(cur_q >> ShW);
          link_wd = (k_q + 1'b1 < cnt_q) ? HW'(GranW'(nxt_obj >> ShW)) + 1'b1 : '0;
        end else begin
          st_d = StOut;
        end
      end
      StOut: if (op_ready_o) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // The link of the current head is read while in the pop state, so the
  // registered data is ready when the head moves on.
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_q <= link_mem[GranW'(head_cur - 1'b1)];
  end

  // Count of objects that fit is found by repeated subtraction, bounded by
  // the refill count so it never runs long.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      hvalid_q <= '0;
      next_q <= '0;
      outv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (outv_q && rsp_ready_i) outv_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          res_q.block_address <= '0;
          res_q.status <= pre;
          objb_q <= nbytes;
        end
        StFree: begin
          heads_q[free_c] <= HW'(gran) + 1'b1;
          hvalid_q[free_c] <= 1'b1;
        end
        StPop: begin
          pop_g_q <= GranW'(head_cur - 1'b1);
          rem_q <= (lim_sat > next_q) ? lim_sat - next_q : '0;
          fit_q <= '0;
          objb_q <= nbytes;
        end
        StLink: begin
          heads_q[alloc_c] <= link_rd_q;
          res_q.block_address <= 16'(pop_g_q) << ShW;
        end
        StFit: begin
          if (rem_q >= objb_q && fit_q < cnt_req) begin
            rem_q <= rem_q - objb_q;
            fit_q <= fit_q + 1'b1;
          end else begin
            if (fit_q == '0) begin
              res_q.status <= scfla_pkg::StatOom;
              cnt_q <= '0;
              k_q <= '0;
            end else begin
              res_q.block_address <= 16'(next_q);
              cnt_q <= fit_q;
              k_q <= PtrW'(1);
              cur_q <= next_q + objb_q;
              if (fit_q > PtrW'(1)) begin
                heads_q[alloc_c] <= HW'(GranW'((next_q + objb_q) >> ShW)) + 1'b1;
                hvalid_q[alloc_c] <= 1'b1;
              end
              next_q <= next_q + PtrW'(fit_q * objb_q);
            end
          end
        end
        StCarve: begin
          if (k_q < cnt_q) begin
            k_q <= k_q + 1'b1;
            cur_q <= nxt_obj;
          end
        end
        StOut: begin
          if (op_ready_o) begin
            outv_q <= 1'b1;
            out_q <= res_q;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && out_q.status != scfla_pkg::StatOk) |-> out_q.block_address == '0)
    else $error("error result carries address");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_ready_o |-> st_q == StOut) else $error("op taken outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= PtrW'(PoolBytes)) else $error("bump pointer past pool");

endmodule
